@@ design/hffc_pkg.sv @@
// Shared codes, widths and constants of the half-precision format converter.
`timescale 1ns / 1ps

package hffc_pkg;

    localparam int unsigned TypeW    = 3;
    localparam int unsigned OperandW = 64;
    localparam int unsigned ResultW  = 64;
    localparam int unsigned HalfW    = 16;
    localparam int unsigned SingleW  = 32;

    // Request kinds
    localparam logic [TypeW-1:0] ReqSglToHalf = 3'd0;
    localparam logic [TypeW-1:0] ReqDblToHalf = 3'd1;
    localparam logic [TypeW-1:0] ReqIntToHalf = 3'd2;
    localparam logic [TypeW-1:0] ReqHalfToSgl = 3'd3;
    localparam logic [TypeW-1:0] ReqHalfToDbl = 3'd4;

    // Largest unbiased half exponent and the half infinity pattern
    localparam logic signed [11:0] HalfExpMax = 12'sd15;
    localparam logic [HalfW-1:0]   HalfInf    = 16'h7C00;

    typedef logic [HalfW-1:0] t_half;

endpackage

@@ design/hffc_req_if.sv @@
// Request channel of the converter: valid/ready with request kind and operand.
`timescale 1ns / 1ps

interface hffc_req_if;
    logic                            valid;
    logic                            ready;
    logic [hffc_pkg::TypeW-1:0]      req_type;
    logic [hffc_pkg::OperandW-1:0]   operand_bits;

    modport source (output valid, output req_type, output operand_bits, input ready);
    modport sink   (input valid, input req_type, input operand_bits, output ready);
endinterface

@@ design/hffc_rsp_if.sv @@
// Result channel of the converter: valid/ready with the converted pattern.
`timescale 1ns / 1ps

interface hffc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hffc_pkg::ResultW-1:0]  result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface

@@ design/hffc_narrow.sv @@
// Single or double to half narrowing with truncation toward zero.
`timescale 1ns / 1ps

module hffc_narrow (
    input  logic [hffc_pkg::OperandW-1:0] i_operand,
    input  logic                          i_is_double,
    output hffc_pkg::t_half               o_half
);

    logic               sign;
    logic [10:0]        expf;
    logic               exp_max;
    logic               mant_nz;
    logic [9:0]         m10;
    logic signed [11:0] e;
    logic [11:0]        d_full;
    logic [3:0]         d;
    logic [10:0]        sub;

    always_comb begin
        if (i_is_double) begin
            sign    = i_operand[63];
            expf    = i_operand[62:52];
            exp_max = (i_operand[62:52] == 11'h7FF);
            mant_nz = (i_operand[51:0] != 52'd0);
            m10     = i_operand[51:42];
            e       = $signed({1'b0, i_operand[62:52]}) - 12'sd1023;
        end else begin
            sign    = i_operand[31];
            expf    = {3'd0, i_operand[30:23]};
            exp_max = (i_operand[30:23] == 8'hFF);
            mant_nz = (i_operand[22:0] != 23'd0);
            m10     = i_operand[22:13];
            e       = $signed({4'd0, i_operand[30:23]}) - 12'sd127;
        end

        // Shift for the subnormal range, 1..10 when used
        d_full = 12'(-12'sd14 - e);
        d      = d_full[3:0];
        sub    = (11'h400 >> d) + ({1'b0, m10} >> d);

        if (expf == 11'd0) begin
            o_half = {sign, 15'd0};
        end else if (exp_max) begin
            o_half = {sign, 15'h7C00} | {15'd0, mant_nz};
        end else if (e < -12'sd24) begin
            o_half = {sign, 15'd0};
        end else if (e < -12'sd14) begin
            o_half = {sign, 5'd0, sub[9:0]};
        end else if (e > hffc_pkg::HalfExpMax) begin
            o_half = {sign, hffc_pkg::HalfInf[14:0]};
        end else begin
            o_half = {sign, 5'(e + hffc_pkg::HalfExpMax), m10};
        end
    end

endmodule

@@ design/hffc_int2half.sv @@
// 32-bit two's-complement integer to half, truncating toward zero.
`timescale 1ns / 1ps

module hffc_int2half (
    input  logic [hffc_pkg::SingleW-1:0] i_word,
    output hffc_pkg::t_half              o_half
);

    logic        sign;
    logic [31:0] mag;
    logic [3:0]  p;
    logic [15:0] norm;

    always_comb begin
        sign = i_word[31];
        mag  = sign ? (~i_word + 32'd1) : i_word;

        // Top set bit of the low half; upper bits overflow to infinity
        p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) begin
                p = 4'(i);
            end
        end
        norm = mag[15:0] << (4'd15 - p);

        if (i_word == 32'd0) begin
            o_half = '0;
        end else if (mag[31:16] != 16'd0) begin
            o_half = {sign, hffc_pkg::HalfInf[14:0]};
        end else begin
            o_half = {sign, 5'({1'b0, p} + 5'd15), norm[14:5]};
        end
    end

endmodule

@@ design/hffc_widen.sv @@
// Exact half to single and half to double widening.
`timescale 1ns / 1ps

module hffc_widen (
    input  hffc_pkg::t_half               i_half,
    output logic [hffc_pkg::SingleW-1:0]  o_single,
    output logic [hffc_pkg::ResultW-1:0]  o_double
);

    logic       sign;
    logic [4:0] ef;
    logic [9:0] m;
    logic [3:0] p;
    logic [9:0] norm;

    always_comb begin
        sign = i_half[15];
        ef   = i_half[14:10];
        m    = i_half[9:0];

        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                p = 4'(i);
            end
        end
        // Bring the leading one to bit 9; the bits below form the fraction
        norm = m << (4'd9 - p);

        if (ef == 5'd0) begin
            if (m == 10'd0) begin
                o_single = {sign, 31'd0};
                o_double = {sign, 63'd0};
            end else begin
                o_single = {sign, 8'(8'd103 + {4'd0, p}), norm[8:0], 14'd0};
                o_double = {sign, 11'(11'd999 + {7'd0, p}), norm[8:0], 43'd0};
            end
        end else if (ef == 5'h1F) begin
            o_single = {sign, 8'hFF, m, 13'd0};
            o_double = {sign, 11'h7FF, m, 42'd0};
        end else begin
            o_single = {sign, 8'({3'd0, ef} + 8'd112), m, 13'd0};
            o_double = {sign, 11'({6'd0, ef} + 11'd1008), m, 42'd0};
        end
    end

endmodule

@@ design/half_float_format_converter.sv @@
// Top level of the half-precision format converter: input register, conversion, result register.
`timescale 1ns / 1ps

// Channel   Direction  Payload                               Accepted when
// i_req     in         req_type[2:0], operand_bits[63:0]     valid & ready
// o_rsp     out        result_bits[63:0]                     valid & ready
//
// An item sits in the input register while the conversion logic works on it and
// then enters the result register, which drives o_rsp.valid. One item is accepted
// per cycle while the result side is not stalled; the conversion path holds no
// state. A stalled result holds in the result register while the input register
// still takes one more item. Reset (synchronous, i_rst_n low) empties both.

module half_float_format_converter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hffc_req_if.sink         i_req,
    hffc_rsp_if.source       o_rsp
);

    // Input stage
    logic                              r_in_valid;
    logic [hffc_pkg::TypeW-1:0]        r_type;
    logic [hffc_pkg::OperandW-1:0]     r_operand;

    // Result stage
    logic                              r_out_valid;
    logic [hffc_pkg::ResultW-1:0]      r_result;

    logic                              out_load_ok;
    logic                              in_ready;
    logic [hffc_pkg::ResultW-1:0]      n_result;

    hffc_pkg::t_half                   narrow_half;
    hffc_pkg::t_half                   int_half;
    logic [hffc_pkg::SingleW-1:0]      wide_single;
    logic [hffc_pkg::ResultW-1:0]      wide_double;

    // The result register can take a new item when empty or being drained.
    assign out_load_ok = !r_out_valid || o_rsp.ready;
    // The input register can take a new item when empty or advancing.
    assign in_ready    = !r_in_valid || out_load_ok;

    assign i_req.ready       = in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_bits = r_result;

    hffc_narrow u_narrow (
        .i_operand   (r_operand),
        .i_is_double (r_type == hffc_pkg::ReqDblToHalf),
        .o_half      (narrow_half)
    );

    hffc_int2half u_int2half (
        .i_word (r_operand[hffc_pkg::SingleW-1:0]),
        .o_half (int_half)
    );

    hffc_widen u_widen (
        .i_half   (r_operand[hffc_pkg::HalfW-1:0]),
        .o_single (wide_single),
        .o_double (wide_double)
    );

    // Pick the converted pattern by request kind; unused kinds give zero.
    always_comb begin
        case (r_type)
            hffc_pkg::ReqSglToHalf,
            hffc_pkg::ReqDblToHalf: n_result = {48'd0, narrow_half};
            hffc_pkg::ReqIntToHalf: n_result = {48'd0, int_half};
            hffc_pkg::ReqHalfToSgl: n_result = {32'd0, wide_single};
            hffc_pkg::ReqHalfToDbl: n_result = wide_double;
            default:                n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_req.valid;
            end
            if (out_load_ok) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Payload: load the input on acceptance, advance the result when it moves.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_type    <= i_req.req_type;
            r_operand <= i_req.operand_bits;
        end
        if (out_load_ok && r_in_valid) begin
            r_result <= n_result;
        end
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the half-precision format converter.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RandomItems = 1200;
    localparam int unsigned CalmTail    = 150;
    localparam int unsigned StallLimit  = 2000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned MaxReports  = 10;
    localparam int unsigned NumDirected = 29;

    // Request kinds with no conversion behind them
    localparam logic [hffc_pkg::TypeW-1:0] ReqSpareLo  = 3'd5;
    localparam logic [hffc_pkg::TypeW-1:0] ReqSpareMid = 3'd6;
    localparam logic [hffc_pkg::TypeW-1:0] ReqSpareHi  = 3'd7;

    typedef struct packed {
        logic [hffc_pkg::TypeW-1:0]    kind;
        logic [hffc_pkg::OperandW-1:0] operand;
        logic                          typed;     // result column below is to be used as is
        logic [hffc_pkg::ResultW-1:0]  result;
    } t_conv_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hffc_req_if req_ch ();
    hffc_rsp_if rsp_ch ();

    half_float_format_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Directed rows: extremes, every kind, every narrowing range, spare kinds.
    t_conv_row directed_rows [NumDirected] = '{
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_0000_0000, 1'b1, 64'h0000},
        '{hffc_pkg::ReqSglToHalf, 64'hFFFF_FFFF_8000_0000, 1'b1, 64'h8000},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_7F80_0000, 1'b1, 64'h7C00},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_FFC0_0001, 1'b1, 64'hFC01},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_3F80_0000, 1'b1, 64'h3C00},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_0000_0001, 1'b1, 64'h0000},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_3380_0000, 1'b0, 64'h0},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_3300_0000, 1'b1, 64'h0000},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_387F_FFFF, 1'b0, 64'h0},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_477F_FFFF, 1'b1, 64'h7BFF},
        '{hffc_pkg::ReqSglToHalf, 64'h0000_0000_4780_0000, 1'b1, 64'h7C00},
        '{hffc_pkg::ReqDblToHalf, 64'h7FF8_0000_0000_0000, 1'b1, 64'h7C01},
        '{hffc_pkg::ReqDblToHalf, 64'hBFF0_0000_0000_0000, 1'b1, 64'hBC00},
        '{hffc_pkg::ReqDblToHalf, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFC01},
        '{hffc_pkg::ReqDblToHalf, 64'h3E70_0000_0000_0001, 1'b0, 64'h0},
        '{hffc_pkg::ReqDblToHalf, 64'h40EF_FC00_0000_0000, 1'b0, 64'h0},
        '{hffc_pkg::ReqIntToHalf, 64'h0000_0000_0000_0000, 1'b1, 64'h0000},
        '{hffc_pkg::ReqIntToHalf, 64'h0000_0000_0000_0001, 1'b1, 64'h3C00},
        '{hffc_pkg::ReqIntToHalf, 64'h0000_0000_8000_0000, 1'b1, 64'hFC00},
        '{hffc_pkg::ReqIntToHalf, 64'h0000_0000_FFFF_FFFF, 1'b1, 64'hBC00},
        '{hffc_pkg::ReqIntToHalf, 64'hDEAD_BEEF_0000_FFE0, 1'b0, 64'h0},
        '{hffc_pkg::ReqHalfToSgl, 64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000},
        '{hffc_pkg::ReqHalfToSgl, 64'hFFFF_FFFF_FFFF_7C00, 1'b1, 64'h7F80_0000},
        '{hffc_pkg::ReqHalfToSgl, 64'h0000_0000_0000_7E00, 1'b1, 64'h7FC0_0000},
        '{hffc_pkg::ReqHalfToSgl, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
        '{hffc_pkg::ReqHalfToDbl, 64'h0000_0000_0000_FC00, 1'b1, 64'hFFF0_0000_0000_0000},
        '{hffc_pkg::ReqHalfToDbl, 64'h0000_0000_0000_83FF, 1'b0, 64'h0},
        '{ReqSpareLo,             64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
        '{ReqSpareHi,             64'h0000_0000_3F80_0000, 1'b1, 64'h0}
    };

    t_conv_row                      stim_q [$];
    logic [hffc_pkg::ResultW-1:0]   converted_due [$];
    t_conv_row                      flight_row = '0;
    t_conv_row                      row;
    logic [hffc_pkg::ResultW-1:0]   want;
    logic                           drive_valid;
    logic                           snk_ready;
    logic                           calm;
    int unsigned                    next_row = 0;
    int unsigned                    accepted_items = 0;
    int unsigned                    src_gap = 0;
    int unsigned                    snk_gap = 0;
    int unsigned                    mismatches = 0;
    int unsigned                    quiet_cycles = 0;

    function automatic int unsigned msb_index(input logic [63:0] v);
        int unsigned p;
        p = 0;
        while (v > 64'd1) begin
            v = v >> 1;
            p++;
        end
        return p;
    endfunction

    // Narrow a wide float (fields already split) to half, truncating.
    function automatic logic [63:0] narrow_half(input logic sign, input int expf,
                                                input logic [63:0] mant, input int mbits,
                                                input int expmax, input int bias);
        logic [63:0] s;
        int          drop;
        int          e;
        int          d;
        s    = 64'(sign) << 15;
        drop = mbits - 10;
        if (expf == 0) return s;
        if (expf == expmax) return s | 64'(hffc_pkg::HalfInf) | 64'(mant != 64'd0);
        e = expf - bias;
        if (e < -24) return s;
        if (e < -14) begin
            d = -14 - e;
            return s | ((64'h400 >> d) + (mant >> (d + drop)));
        end
        if (e > int'(hffc_pkg::HalfExpMax)) return s | 64'(hffc_pkg::HalfInf);
        return s | (64'(e + 15) << 10) | ((mant >> drop) & 64'h3FF);
    endfunction

    // Widen half exactly; subnormals get normalized.
    function automatic logic [63:0] widen_half(input logic [15:0] h, input int mbits,
                                               input logic [63:0] expmax,
                                               input logic [63:0] bias, input int signpos);
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] mmask;
        logic [4:0]  ef;
        int unsigned p;
        s     = 64'(h[15]) << signpos;
        ef    = h[14:10];
        m     = 64'(h[9:0]);
        mmask = (64'd1 << mbits) - 64'd1;
        if (ef == 5'd0) begin
            if (m == 64'd0) return s;
            p = msb_index(m);
            return s | ((bias + 64'(p) - 64'd24) << mbits) | ((m << (mbits - p)) & mmask);
        end
        if (ef == 5'd31) return s | (expmax << mbits) | (m << (mbits - 10));
        return s | ((64'(ef) - 64'd15 + bias) << mbits) | (m << (mbits - 10));
    endfunction

    function automatic logic [63:0] int_as_double(input logic [31:0] w);
        logic [31:0] negw;
        logic [63:0] mag;
        int unsigned p;
        if (w == 32'd0) return 64'd0;
        negw = ~w + 32'd1;
        mag  = w[31] ? 64'(negw) : 64'(w);
        p    = msb_index(mag);
        return (64'(w[31]) << 63) | (64'(p + 1023) << 52) |
               ((mag << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF);
    endfunction

    function automatic logic [hffc_pkg::ResultW-1:0] convert_pattern(
        input logic [hffc_pkg::TypeW-1:0]    kind,
        input logic [hffc_pkg::OperandW-1:0] op
    );
        logic [63:0] dbl;
        case (kind)
            hffc_pkg::ReqSglToHalf: return narrow_half(op[31], int'(op[30:23]),
                                                       64'(op[22:0]), 23, 255, 127);
            hffc_pkg::ReqDblToHalf: return narrow_half(op[63], int'(op[62:52]),
                                                       64'(op[51:0]), 52, 2047, 1023);
            hffc_pkg::ReqIntToHalf: begin
                dbl = int_as_double(op[31:0]);
                return narrow_half(dbl[63], int'(dbl[62:52]), 64'(dbl[51:0]),
                                   52, 2047, 1023);
            end
            hffc_pkg::ReqHalfToSgl: return widen_half(op[15:0], 23, 64'hFF, 64'd127, 31);
            hffc_pkg::ReqHalfToDbl: return widen_half(op[15:0], 52, 64'h7FF, 64'd1023, 63);
            default:                return 64'd0;
        endcase
    endfunction

    // Random operand; exponents lean toward the half range so every narrowing
    // branch gets hit, with full-width noise mixed in.
    function automatic logic [hffc_pkg::OperandW-1:0] pick_operand(
        input logic [hffc_pkg::TypeW-1:0] kind
    );
        logic [63:0] noise;
        logic [10:0] ex;
        logic [31:0] w;
        int unsigned mode;
        noise = {$urandom, $urandom};
        mode  = $urandom_range(0, 7);
        case (kind)
            hffc_pkg::ReqSglToHalf: begin
                if (mode < 4)       ex = 11'($urandom_range(95, 145));
                else if (mode == 4) ex = 11'd0;
                else if (mode == 5) ex = 11'd255;
                else                ex = 11'($urandom_range(0, 255));
                return {noise[63:31], ex[7:0], noise[22:0]};
            end
            hffc_pkg::ReqDblToHalf: begin
                if (mode < 4)       ex = 11'($urandom_range(995, 1041));
                else if (mode == 4) ex = 11'd0;
                else if (mode == 5) ex = 11'd2047;
                else                ex = 11'($urandom_range(0, 2047));
                return {noise[63], ex, noise[51:0]};
            end
            hffc_pkg::ReqIntToHalf: begin
                if (mode < 3)      w = 32'($urandom_range(0, 70000));
                else if (mode < 5) w = 32'($urandom) >> $urandom_range(0, 31);
                else               w = $urandom;
                if (mode < 5 && $urandom_range(0, 1) == 1) w = ~w + 32'd1;
                return {noise[63:32], w};
            end
            default: begin
                if (mode == 0)      ex = 11'd0;
                else if (mode == 1) ex = 11'd31;
                else                ex = 11'($urandom_range(0, 31));
                return {noise[63:15], ex[4:0], noise[9:0]};
            end
        endcase
    endfunction

    // Stimulus, source side and result check share one clocked process.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid        <= 1'b0;
            req_ch.req_type     <= '0;
            req_ch.operand_bits <= '0;
            rsp_ch.ready        <= 1'b0;
        end else begin
            calm = (next_row + CalmTail >= stim_q.size());

            // Request accepted: queue what it must come back as.
            if (req_ch.valid && req_ch.ready) begin
                if (flight_row.typed)
                    converted_due.push_back(flight_row.result);
                else
                    converted_due.push_back(convert_pattern(req_ch.req_type,
                                                            req_ch.operand_bits));
                accepted_items++;
            end

            // Load the next item once the current one is gone.
            if (!req_ch.valid || req_ch.ready) begin
                drive_valid = 1'b0;
                if (src_gap != 0) begin
                    src_gap--;
                end else if (next_row < stim_q.size()) begin
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        src_gap = $urandom_range(0, 18);
                    end else begin
                        row        = stim_q[next_row];
                        flight_row = row;
                        next_row++;
                        req_ch.req_type     <= row.kind;
                        req_ch.operand_bits <= row.operand;
                        drive_valid = 1'b1;
                    end
                end
                req_ch.valid <= drive_valid;
            end

            // Result accepted: compare with the oldest one due.
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (converted_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("unexpected result %h", rsp_ch.result_bits);
                end else begin
                    want = converted_due.pop_front();
                    if (rsp_ch.result_bits !== want) begin
                        mismatches++;
                        if (mismatches <= MaxReports)
                            $display("result_bits mismatch: expected %h actual %h",
                                     want, rsp_ch.result_bits);
                    end
                end
            end

            // Stall the result side in bursts, never in the calm tail.
            if (calm) begin
                snk_ready = 1'b1;
            end else if (snk_gap != 0) begin
                snk_gap--;
                snk_ready = 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                snk_gap   = $urandom_range(0, 18);
                snk_ready = 1'b0;
            end else begin
                snk_ready = 1'b1;
            end
            rsp_ch.ready <= snk_ready;
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("half_float_format_converter test failed");
                $finish;
            end
        end
    end

    initial begin
        t_conv_row build_row;

        i_rst_n = 1'b0;

        for (int i = 0; i < NumDirected; i++)
            stim_q.push_back(directed_rows[i]);
        for (int i = 0; i < RandomItems; i++) begin
            build_row.kind    = ($urandom_range(0, 15) == 0) ?
                                3'($urandom_range(ReqSpareLo, ReqSpareHi)) :
                                3'($urandom_range(hffc_pkg::ReqSglToHalf,
                                                  hffc_pkg::ReqHalfToDbl));
            build_row.operand = pick_operand(build_row.kind);
            build_row.typed   = 1'b0;
            build_row.result  = '0;
            stim_q.push_back(build_row);
        end
        // Spare middle kind once with a typed zero
        build_row = '{ReqSpareMid, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 64'h0};
        stim_q.push_back(build_row);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_items < stim_q.size() || converted_due.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0)
            $display("half_float_format_converter test passed");
        else
            $display("half_float_format_converter test failed");
        $finish;
    end

endmodule
